@@ hw/rtl/df1iir_pkg.sv @@
package df1iir_pkg;

  localparam int MAX_TAPS_DEFAULT = 16;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int COUNT_W  = 5;
  localparam int SCALE_W  = 32;
  localparam int CFG_IDX_W = 2;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_COEF   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Coefficient bank codes.
  localparam logic BANK_FF = 1'b0;
  localparam logic BANK_FB = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FF_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_FF,
    ST_FB,
    ST_DRAIN,
    ST_ROUND,
    ST_SCALE,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic acc_clr;
    logic issue;
    logic issue_sub;
    logic round_en;
    logic scale_sel;
  } ctl_t;

  typedef struct packed {
    logic                busy;
    logic                sat;
    logic [SAMPLE_W-1:0] y;
  } status_t;

endpackage

@@ hw/rtl/df1iir_in_if.sv @@
interface df1iir_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             req_type;
  logic signed [df1iir_pkg::SAMPLE_W-1:0] sample_in;
  logic                                   coef_bank;
  logic [3:0]                             coef_index;
  logic signed [df1iir_pkg::COEF_W-1:0]   coef_value;

  modport source (
    output valid, req_type, sample_in, coef_bank, coef_index, coef_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, sample_in, coef_bank, coef_index, coef_value,
    output ready
  );
endinterface

@@ hw/rtl/df1iir_out_if.sv @@
interface df1iir_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [df1iir_pkg::SAMPLE_W-1:0] filtered_sample;
  logic                                   saturated;

  modport source (
    output valid, filtered_sample, saturated,
    input  ready
  );

  modport sink (
    input  valid, filtered_sample, saturated,
    output ready
  );
endinterface

@@ hw/rtl/direct_form_one_iir_filter.sv @@
// Direct form I IIR filter with one shared multiply-accumulate unit.
// Items arrive on the request channel: a sample, a coefficient write or a
// history clear. Only a sample item yields an item on the result channel.
// The configuration port writes the two tap counts and the output scale;
// the user must write it only while the filter is idle; the block does not enforce this.
// For a sample item the multiplier takes one tap a cycle over nb feedforward
// and na - 1 feedback taps, where nb and na are the feedforward and feedback
// counts in use; then the drain, rounding, scaling (the multiplier's last use)
// and output steps follow. Request ready rises again with the result.
// A coefficient write is taken without leaving the idle state; a clear item
// sweeps both histories to zero. After reset a sweep zeroes all four stores;
// request ready stays low meanwhile. The result sits in an output register:
// if the receiver stalls, one finished result waits there while further
// coefficient and clear items are taken; a following sample holds its result
// until the register frees.
module direct_form_one_iir_filter #(
  parameter int MAX_TAPS = df1iir_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  df1iir_in_if.sink                           request,
  df1iir_out_if.source                        result,
  input  logic                                cfg_wr_en,
  input  logic [df1iir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [df1iir_pkg::SCALE_W-1:0]      cfg_data
);

  localparam int AW = $clog2(MAX_TAPS);

  logic [df1iir_pkg::COUNT_W-1:0]        ff_count, fb_count;
  logic signed [df1iir_pkg::SCALE_W-1:0] output_scale;

  df1iir_pkg::ctl_t    ctl;
  df1iir_pkg::status_t status;
  logic                out_load, out_free, res_valid;

  logic                                   ih_we, oh_we, ff_we, fb_we;
  logic [AW-1:0]                          hist_waddr, coef_waddr, coef_raddr, hist_raddr;
  logic signed [df1iir_pkg::SAMPLE_W-1:0] ih_wdata, oh_wdata, ih_rd, oh_rd;
  logic signed [df1iir_pkg::COEF_W-1:0]   coef_wdata, ff_rd, fb_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      ff_count     <= 5'd1;
      fb_count     <= 5'd1;
      output_scale <= 32'sd65536;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        df1iir_pkg::CFG_FF_COUNT: ff_count     <= cfg_data[df1iir_pkg::COUNT_W-1:0];
        df1iir_pkg::CFG_FB_COUNT: fb_count     <= cfg_data[df1iir_pkg::COUNT_W-1:0];
        df1iir_pkg::CFG_SCALE:    output_scale <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  df1iir_seq #(.MAX_TAPS(MAX_TAPS)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .ff_count   (ff_count),
    .fb_count   (fb_count),
    .out_free   (out_free),
    .status     (status),
    .ctl        (ctl),
    .out_load   (out_load),
    .ih_we      (ih_we),
    .oh_we      (oh_we),
    .hist_waddr (hist_waddr),
    .ih_wdata   (ih_wdata),
    .oh_wdata   (oh_wdata),
    .ff_we      (ff_we),
    .fb_we      (fb_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .coef_raddr (coef_raddr),
    .hist_raddr (hist_raddr)
  );

  df1iir_ram #(.DEPTH(MAX_TAPS), .WIDTH(df1iir_pkg::SAMPLE_W)) u_in_hist (
    .clk   (clk),
    .we    (ih_we),
    .waddr (hist_waddr),
    .wdata (ih_wdata),
    .raddr (hist_raddr),
    .rdata (ih_rd)
  );

  df1iir_ram #(.DEPTH(MAX_TAPS), .WIDTH(df1iir_pkg::SAMPLE_W)) u_out_hist (
    .clk   (clk),
    .we    (oh_we),
    .waddr (hist_waddr),
    .wdata (oh_wdata),
    .raddr (hist_raddr),
    .rdata (oh_rd)
  );

  df1iir_ram #(.DEPTH(MAX_TAPS), .WIDTH(df1iir_pkg::COEF_W)) u_ff_coef (
    .clk   (clk),
    .we    (ff_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (ff_rd)
  );

  df1iir_ram #(.DEPTH(MAX_TAPS), .WIDTH(df1iir_pkg::COEF_W)) u_fb_coef (
    .clk   (clk),
    .we    (fb_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (fb_rd)
  );

  df1iir_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .scale  (output_scale),
    .ff_rd  (ff_rd),
    .fb_rd  (fb_rd),
    .ih_rd  (ih_rd),
    .oh_rd  (oh_rd),
    .status (status)
  );

  assign out_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.filtered_sample <= status.y;
      result.saturated       <= status.sat;
    end
  end

  assign result.valid = res_valid;

endmodule

@@ hw/rtl/df1iir_ram.sv @@
module df1iir_ram #(
  parameter int DEPTH = df1iir_pkg::MAX_TAPS_DEFAULT,
  parameter int WIDTH = df1iir_pkg::SAMPLE_W,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/df1iir_dp.sv @@
module df1iir_dp #(
  parameter int MAX_TAPS = df1iir_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  df1iir_pkg::ctl_t                       ctl,
  input  logic signed [df1iir_pkg::SCALE_W-1:0]  scale,
  input  logic signed [df1iir_pkg::COEF_W-1:0]   ff_rd,
  input  logic signed [df1iir_pkg::COEF_W-1:0]   fb_rd,
  input  logic signed [df1iir_pkg::SAMPLE_W-1:0] ih_rd,
  input  logic signed [df1iir_pkg::SAMPLE_W-1:0] oh_rd,
  output df1iir_pkg::status_t                    status
);

  localparam int CW   = df1iir_pkg::COEF_W;
  localparam int SW   = df1iir_pkg::SAMPLE_W;
  localparam int KW   = df1iir_pkg::SCALE_W;
  // Each tap product is 40 bits; the sum of up to 2*MAX_TAPS of them grows by the log.
  localparam int ACC_W = CW + SW + $clog2(2 * MAX_TAPS);
  localparam int MA_W  = ACC_W - 19;
  localparam int P_W   = MA_W + KW;
  localparam int ZW    = P_W - 15;

  localparam logic signed [ACC_W:0] HALF20 = (ACC_W + 1)'(2 ** 19);
  localparam logic signed [P_W:0]   HALF16 = (P_W + 1)'(2 ** 15);
  localparam logic signed [ZW-1:0]  ZMAX   = ZW'(32767);
  localparam logic signed [ZW-1:0]  ZMIN   = -(ZW'(32768));

  logic                    t1_v, t1_sub, t2_v, t2_sub;
  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [MA_W-1:0]  y15;

  logic signed [CW-1:0]    coef_sel;
  logic signed [SW-1:0]    hist_sel;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [KW-1:0]    mul_b;
  logic signed [ACC_W-1:0] prod_tr;
  logic signed [ACC_W:0]   acc_rnd;
  logic signed [P_W:0]     scl_rnd;
  logic signed [ZW-1:0]    z;

  // Tag stage t1 lines up with the memory read data and stage t2 with the product.
  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v   <= 1'b0;
      t1_sub <= 1'b0;
      t2_v   <= 1'b0;
      t2_sub <= 1'b0;
    end else begin
      t1_v   <= ctl.issue;
      t1_sub <= ctl.issue_sub;
      t2_v   <= t1_v;
      t2_sub <= t1_sub;
    end
  end

  always_comb begin
    coef_sel = t1_sub ? fb_rd : ff_rd;
    hist_sel = t1_sub ? oh_rd : ih_rd;
    if (ctl.scale_sel) begin
      mul_a = y15;
      mul_b = scale;
    end else begin
      mul_a = {{(MA_W - CW){coef_sel[CW-1]}}, coef_sel};
      mul_b = {{(KW - SW){hist_sel[SW-1]}}, hist_sel};
    end
  end

  // The one shared multiplier serves both the tap products and the output scaling.
  always_ff @(posedge clk) begin
    if (t1_v || ctl.scale_sel) begin
      prod <= mul_a * mul_b;
    end
  end

  assign prod_tr = prod[ACC_W-1:0];
  assign acc_rnd = {acc[ACC_W-1], acc} + HALF20;

  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (t2_v) begin
      acc <= t2_sub ? (acc - prod_tr) : (acc + prod_tr);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.round_en) begin
      y15 <= acc_rnd[ACC_W:20];
    end
  end

  assign scl_rnd = {prod[P_W-1], prod} + HALF16;
  assign z       = scl_rnd[P_W:16];

  always_comb begin
    status.busy = t1_v || t2_v;
    if (z > ZMAX) begin
      status.y   = 16'h7FFF;
      status.sat = 1'b1;
    end else if (z < ZMIN) begin
      status.y   = 16'h8000;
      status.sat = 1'b1;
    end else begin
      status.y   = z[SW-1:0];
      status.sat = 1'b0;
    end
  end

endmodule

@@ hw/rtl/df1iir_seq.sv @@
module df1iir_seq #(
  parameter int MAX_TAPS = df1iir_pkg::MAX_TAPS_DEFAULT,
  localparam int AW = $clog2(MAX_TAPS)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  df1iir_in_if.sink                              request,
  input  logic [df1iir_pkg::COUNT_W-1:0]         ff_count,
  input  logic [df1iir_pkg::COUNT_W-1:0]         fb_count,
  input  logic                                   out_free,
  input  df1iir_pkg::status_t                    status,
  output df1iir_pkg::ctl_t                       ctl,
  output logic                                   out_load,
  output logic                                   ih_we,
  output logic                                   oh_we,
  output logic [AW-1:0]                          hist_waddr,
  output logic signed [df1iir_pkg::SAMPLE_W-1:0] ih_wdata,
  output logic signed [df1iir_pkg::SAMPLE_W-1:0] oh_wdata,
  output logic                                   ff_we,
  output logic                                   fb_we,
  output logic [AW-1:0]                          coef_waddr,
  output logic signed [df1iir_pkg::COEF_W-1:0]   coef_wdata,
  output logic [AW-1:0]                          coef_raddr,
  output logic [AW-1:0]                          hist_raddr
);

  localparam logic [AW-1:0] LAST  = AW'(MAX_TAPS - 1);
  localparam logic [7:0]    MAXT8 = 8'(MAX_TAPS);

  df1iir_pkg::state_t state, state_next;
  logic [AW-1:0] cnt, ha, hp;
  logic [AW-1:0] hp_dec, hp_inc, ha_inc;
  logic [AW-1:0] ff_last, fb_last;
  logic [7:0]    ffc8, fbc8, ffm8, fbm8, idx8;
  logic          accept, take_sample, take_coef, idx_ok, sweep;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == LAST) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
    return (a == '0) ? LAST : a - 1'b1;
  endfunction

  // The histories are circular: entry i of a history lives at hp + i.
  assign hp_dec = wrap_dec(hp);
  assign hp_inc = wrap_inc(hp);
  assign ha_inc = wrap_inc(ha);

  // A count of zero acts as one, and any count above the depth acts as the depth.
  assign ffc8 = {3'b000, ff_count};
  assign fbc8 = {3'b000, fb_count};
  assign ffm8 = ffc8 - 8'd1;
  assign fbm8 = fbc8 - 8'd1;

  always_comb begin
    if (ffc8 == 8'd0) begin
      ff_last = '0;
    end else if (ffc8 > MAXT8) begin
      ff_last = LAST;
    end else begin
      ff_last = ffm8[AW-1:0];
    end
    if (fbc8 == 8'd0) begin
      fb_last = '0;
    end else if (fbc8 > MAXT8) begin
      fb_last = LAST;
    end else begin
      fb_last = fbm8[AW-1:0];
    end
  end

  assign request.ready = (state == df1iir_pkg::ST_IDLE);
  assign accept        = request.valid && request.ready;
  assign take_sample   = accept && (request.req_type == df1iir_pkg::REQ_SAMPLE);
  assign take_coef     = accept && (request.req_type == df1iir_pkg::REQ_COEF);
  assign idx8          = {4'b0000, request.coef_index};
  assign idx_ok        = idx8 < MAXT8;

  always_comb begin
    state_next = state;
    unique case (state)
      df1iir_pkg::ST_INIT, df1iir_pkg::ST_CLEAR: begin
        if (cnt == LAST) begin
          state_next = df1iir_pkg::ST_IDLE;
        end
      end
      df1iir_pkg::ST_IDLE: begin
        if (request.valid) begin
          unique case (request.req_type)
            df1iir_pkg::REQ_SAMPLE: state_next = df1iir_pkg::ST_FF;
            df1iir_pkg::REQ_CLEAR:  state_next = df1iir_pkg::ST_CLEAR;
            default:                state_next = df1iir_pkg::ST_IDLE;
          endcase
        end
      end
      df1iir_pkg::ST_FF: begin
        if (cnt == ff_last) begin
          state_next = (fb_last == '0) ? df1iir_pkg::ST_DRAIN : df1iir_pkg::ST_FB;
        end
      end
      df1iir_pkg::ST_FB: begin
        if (cnt == fb_last) begin
          state_next = df1iir_pkg::ST_DRAIN;
        end
      end
      df1iir_pkg::ST_DRAIN: begin
        if (!status.busy) begin
          state_next = df1iir_pkg::ST_ROUND;
        end
      end
      df1iir_pkg::ST_ROUND: state_next = df1iir_pkg::ST_SCALE;
      df1iir_pkg::ST_SCALE: state_next = df1iir_pkg::ST_HOLD;
      df1iir_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = df1iir_pkg::ST_IDLE;
        end
      end
      default: state_next = df1iir_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= df1iir_pkg::ST_INIT;
      cnt   <= '0;
      ha    <= '0;
      hp    <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        df1iir_pkg::ST_INIT, df1iir_pkg::ST_CLEAR: begin
          cnt <= wrap_inc(cnt);
        end
        df1iir_pkg::ST_IDLE: begin
          if (accept) begin
            cnt <= '0;
          end
          if (take_sample) begin
            hp <= hp_dec;
            ha <= hp_dec;
          end
        end
        df1iir_pkg::ST_FF: begin
          if (cnt == ff_last) begin
            cnt <= AW'(1);
            ha  <= hp_inc;
          end else begin
            cnt <= cnt + 1'b1;
            ha  <= ha_inc;
          end
        end
        df1iir_pkg::ST_FB: begin
          cnt <= cnt + 1'b1;
          ha  <= ha_inc;
        end
        default: begin
        end
      endcase
    end
  end

  assign sweep = (state == df1iir_pkg::ST_INIT) || (state == df1iir_pkg::ST_CLEAR);

  always_comb begin
    ctl.acc_clr   = take_sample;
    ctl.issue     = (state == df1iir_pkg::ST_FF) || (state == df1iir_pkg::ST_FB);
    ctl.issue_sub = (state == df1iir_pkg::ST_FB);
    ctl.round_en  = (state == df1iir_pkg::ST_ROUND);
    ctl.scale_sel = (state == df1iir_pkg::ST_SCALE);
    out_load      = (state == df1iir_pkg::ST_HOLD) && out_free;

    ih_we      = sweep || take_sample;
    oh_we      = sweep || out_load;
    ih_wdata   = take_sample ? request.sample_in : '0;
    oh_wdata   = out_load ? status.y : '0;
    if (sweep) begin
      hist_waddr = cnt;
    end else if (out_load) begin
      hist_waddr = hp;
    end else begin
      hist_waddr = hp_dec;
    end

    ff_we      = (state == df1iir_pkg::ST_INIT) ||
                 (take_coef && idx_ok && (request.coef_bank == df1iir_pkg::BANK_FF));
    fb_we      = (state == df1iir_pkg::ST_INIT) ||
                 (take_coef && idx_ok && (request.coef_bank == df1iir_pkg::BANK_FB));
    coef_waddr = (state == df1iir_pkg::ST_INIT) ? cnt : idx8[AW-1:0];
    coef_wdata = (state == df1iir_pkg::ST_INIT) ? '0 : request.coef_value;

    coef_raddr = cnt;
    hist_raddr = ha;
  end

endmodule
